@@ rtl/bcud_pkg.sv @@
// Package for the byte charset to UCS-2 decoder.
// Holds the mode codes, the state and result types and the Latin-2 upper table.
// No dependencies.
package bcud_pkg;

   typedef enum logic [1:0] {
      MODE_LATIN1 = 2'd0,
      MODE_LATIN2 = 2'd1,
      MODE_UTF8   = 2'd2
   } bcud_mode_type;

   typedef struct packed {
      logic [1:0]  pending;
      logic [15:0] partial;
   } bcud_state_type;

   typedef struct packed {
      logic        emit;
      logic [15:0] code_point;
      logic        bad_lead;
   } bcud_result_type;

   localparam logic [7:0] LATIN2_BASE = 8'hA0;
   localparam int         LATIN2_SIZE = 96;

   localparam logic [15:0] LATIN2_UPPER [LATIN2_SIZE] = '{
      16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
      16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
      16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
      16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C,
      16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
      16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
      16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
      16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
      16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
      16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
      16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
      16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
   };

endpackage

@@ rtl/bcud_step.sv @@
// Decode step: one byte plus the current UTF-8 partial state gives the next
// state and an optional result. Pure combinational logic; uses bcud_pkg.
module bcud_step (
   input  logic [1:0]              mode,
   input  logic [7:0]              in_byte,
   input  bcud_pkg::bcud_state_type state_cur,
   output bcud_pkg::bcud_state_type state_nxt,
   output bcud_pkg::bcud_result_type result
);
   import bcud_pkg::*;

   logic [6:0]  latin2_idx;
   logic [15:0] cont_bits;
   logic [15:0] merged;

   assign latin2_idx = 7'(in_byte - LATIN2_BASE);

   always_comb begin
      case (state_cur.pending)
         2'd2:    cont_bits = {4'd0, in_byte[5:0], 6'd0};
         2'd3:    cont_bits = {in_byte[3:0], 12'd0};
         default: cont_bits = {10'd0, in_byte[5:0]};
      endcase
   end

   assign merged = state_cur.partial | cont_bits;

   always_comb begin
      state_nxt         = state_cur;
      result.emit       = 1'b1;
      result.code_point = {8'd0, in_byte};
      result.bad_lead   = 1'b0;
      case (mode)
         MODE_UTF8: begin
            if (state_cur.pending != 2'd0) begin
               state_nxt.pending = state_cur.pending - 2'd1;
               if (state_cur.pending == 2'd1) begin
                  state_nxt.partial = 16'd0;
                  result.code_point = merged;
               end else begin
                  state_nxt.partial = merged;
                  result.emit       = 1'b0;
               end
            end else if (!in_byte[7]) begin
               result.code_point = {8'd0, in_byte};
            end else if (!in_byte[5]) begin
               state_nxt.pending = 2'd1;
               state_nxt.partial = {5'd0, in_byte[4:0], 6'd0};
               result.emit       = 1'b0;
            end else if (!in_byte[4]) begin
               state_nxt.pending = 2'd2;
               state_nxt.partial = {in_byte[3:0], 12'd0};
               result.emit       = 1'b0;
            end else begin
               state_nxt.pending = 2'd0;
               state_nxt.partial = 16'd0;
               result.code_point = 16'd0;
               result.bad_lead   = 1'b1;
            end
         end
         MODE_LATIN2: begin
            if (in_byte >= LATIN2_BASE) begin
               result.code_point = LATIN2_UPPER[latin2_idx];
            end
         end
         default: begin
            result.code_point = {8'd0, in_byte};
         end
      endcase
   end

endmodule

@@ rtl/byte_charset_to_ucs2_decoder.sv @@
// Byte charset to UCS-2 decoder, top level.
// Uses bcud_pkg and bcud_step.
//
// Converts a byte stream to 16-bit code points in Latin-1, Latin-2 or UTF-8
// as chosen by the mode register. Each byte is captured in an input
// register, decoded by the step logic and written to the result register,
// so a byte can be accepted every cycle while the result is not stalled;
// the UTF-8 partial state is updated as each byte advances. In UTF-8
// mode a result appears only on the last byte of a sequence, and a lead
// byte of the form 1x11xxxx gives a result with bad_lead set and code point
// zero. Write the mode only while no transaction is in flight; the write
// clears any partial UTF-8 sequence.
module byte_charset_to_ucs2_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_code_point,
   output logic        rsp_bad_lead,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_coding_mode
);
   import bcud_pkg::*;

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   logic [1:0]      mode_ff;
   bcud_state_type  state_ff, state_in;
   bcud_result_type step_res;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [15:0]     rsp_code_point_ff;
   logic            rsp_bad_lead_ff;
   logic            out_free;
   logic            advance;
   logic            req_take;
   logic            csr_take;

   bcud_step u_step (
      .mode      (mode_ff),
      .in_byte   (in_byte_ff),
      .state_cur (state_ff),
      .state_nxt (state_in),
      .result    (step_res)
   );

   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign advance     = in_valid_ff && out_free;
   assign req_stall   = reset || (in_valid_ff && !out_free);
   assign req_take    = req_valid && !req_stall;
   assign csr_ready   = !reset && !in_valid_ff && !rsp_valid_ff;
   assign csr_take    = csr_valid && csr_ready;
   assign in_valid_in = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_free ? (advance && step_res.emit) : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= MODE_LATIN1;
         state_ff     <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_take) begin
            mode_ff  <= csr_coding_mode;
            state_ff <= '0;
         end else if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && step_res.emit) begin
         rsp_code_point_ff <= step_res.code_point;
         rsp_bad_lead_ff   <= step_res.bad_lead;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_code_point_ff;
   assign rsp_bad_lead   = rsp_bad_lead_ff;

endmodule

@@ rtl/bcud_checker.sv @@
// Port-level checks for the byte charset to UCS-2 decoder.
// Bound to byte_charset_to_ucs2_decoder; no other dependencies.
module bcud_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_code_point,
   input logic        rsp_bad_lead,
   input logic        csr_ready
);

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_lead |-> rsp_code_point == 16'd0)
      else $error("bad lead result with nonzero code point");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !rsp_valid && !req_stall)
      else $error("config port ready while a transaction is in flight");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid && (reset || csr_ready))
      else $error("result valid or config blocked after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_code_point)
         && $stable(rsp_bad_lead))
      else $error("stalled result changed");

endmodule

bind byte_charset_to_ucs2_decoder bcud_checker u_bcud_checker (.*);

@@ sim/byte_charset_to_ucs2_decoder_checker.sv @@
// Checker for the byte charset to UCS-2 decoder: watches the byte, result and mode channels,
// predicts each code point from its own decoder state and compares in order.
// Depends on bcud_pkg for the mode codes.
module byte_charset_to_ucs2_decoder_checker
   import bcud_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_in_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_code_point,
   input  logic        rsp_bad_lead,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [1:0]  csr_coding_mode,
   output int          mismatch_count,
   output int          chars_outstanding
);

   typedef struct packed {
      logic [15:0] code_point;
      logic        bad_lead;
   } ucs2_char_type;

   localparam logic [7:0] ISO8859_2_FIRST = 8'hA0;

   localparam logic [15:0] ISO8859_2_HIGH [96] = '{
      16'h00A0, 16'h0104, 16'h02D8, 16'h0141, 16'h00A4, 16'h013D, 16'h015A, 16'h00A7,
      16'h00A8, 16'h0160, 16'h015E, 16'h0164, 16'h0179, 16'h00AD, 16'h017D, 16'h017B,
      16'h00B0, 16'h0105, 16'h02DB, 16'h0142, 16'h00B4, 16'h013E, 16'h015B, 16'h02C7,
      16'h00B8, 16'h0161, 16'h015F, 16'h0165, 16'h017A, 16'h02DD, 16'h017E, 16'h017C,
      16'h0154, 16'h00C1, 16'h00C2, 16'h0102, 16'h00C4, 16'h0139, 16'h0106, 16'h00C7,
      16'h010C, 16'h00C9, 16'h0118, 16'h00CB, 16'h011A, 16'h00CD, 16'h00CE, 16'h010E,
      16'h0110, 16'h0143, 16'h0147, 16'h00D3, 16'h00D4, 16'h0150, 16'h00D6, 16'h00D7,
      16'h0158, 16'h016E, 16'h00DA, 16'h0170, 16'h00DC, 16'h00DD, 16'h0162, 16'h00DF,
      16'h0155, 16'h00E1, 16'h00E2, 16'h0103, 16'h00E4, 16'h013A, 16'h0107, 16'h00E7,
      16'h010D, 16'h00E9, 16'h0119, 16'h00EB, 16'h011B, 16'h00ED, 16'h00EE, 16'h010F,
      16'h0111, 16'h0144, 16'h0148, 16'h00F3, 16'h00F4, 16'h0151, 16'h00F6, 16'h00F7,
      16'h0159, 16'h016F, 16'h00FA, 16'h0171, 16'h00FC, 16'h00FD, 16'h0163, 16'h02D9
   };

   logic [1:0]    active_mode;
   logic [1:0]    utf8_remaining;
   logic [15:0]   utf8_partial;
   ucs2_char_type awaited_chars[$];

   task automatic decode_byte(input logic [7:0] b);
      ucs2_char_type next_char;
      next_char = '{code_point: {8'h00, b}, bad_lead: 1'b0};
      if (active_mode == MODE_UTF8) begin
         if (utf8_remaining != 2'd0) begin
            utf8_partial = utf8_partial | (16'(b[5:0]) << (6 * (utf8_remaining - 2'd1)));
            utf8_remaining = utf8_remaining - 2'd1;
            if (utf8_remaining != 2'd0) return;
            next_char.code_point = utf8_partial;
            utf8_partial = '0;
         end else if (b[7] && !b[5]) begin
            utf8_partial = 16'(b[4:0]) << 6;
            utf8_remaining = 2'd1;
            return;
         end else if (b[7] && !b[4]) begin
            utf8_partial = 16'(b[3:0]) << 12;
            utf8_remaining = 2'd2;
            return;
         end else if (b[7]) begin
            utf8_partial = '0;
            utf8_remaining = 2'd0;
            next_char = '{code_point: 16'h0000, bad_lead: 1'b1};
         end
      end else if (active_mode == MODE_LATIN2 && b >= ISO8859_2_FIRST) begin
         next_char.code_point = ISO8859_2_HIGH[7'(b - ISO8859_2_FIRST)];
      end
      awaited_chars.push_back(next_char);
   endtask

   always @(posedge clock) begin
      ucs2_char_type want;
      if (reset) begin
         active_mode <= MODE_LATIN1;
         utf8_remaining = '0;
         utf8_partial = '0;
         mismatch_count = 0;
         awaited_chars.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            active_mode <= csr_coding_mode;
            utf8_remaining = '0;
            utf8_partial = '0;
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_chars.size() == 0) begin
               $error("unexpected result: code_point %h bad_lead %b",
                      rsp_code_point, rsp_bad_lead);
               mismatch_count++;
            end else begin
               want = awaited_chars.pop_front();
               if (rsp_code_point !== want.code_point) begin
                  $error("code_point: expected %h, actual %h", want.code_point, rsp_code_point);
                  mismatch_count++;
               end
               if (rsp_bad_lead !== want.bad_lead) begin
                  $error("bad_lead: expected %b, actual %b", want.bad_lead, rsp_bad_lead);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) decode_byte(req_in_byte);
      end
      chars_outstanding <= awaited_chars.size();
   end

endmodule

@@ sim/tb_byte_charset_to_ucs2_decoder.sv @@
// Testbench top for the byte charset to UCS-2 decoder: drives bytes and mode writes
// with random gaps and stalls, and reports the verdict.
// Depends on bcud_pkg, the decoder and byte_charset_to_ucs2_decoder_checker.
module tb_byte_charset_to_ucs2_decoder;
   import bcud_pkg::*;

   localparam logic [1:0] MODE_UNDEFINED = 2'd3;
   localparam int SETTLE_CYCLES = 6;
   localparam int PHASE_BYTES = 250;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] PHASE_MODES [8] = '{
      MODE_UTF8, MODE_LATIN2, MODE_LATIN1, MODE_UTF8,
      MODE_UNDEFINED, MODE_UTF8, MODE_LATIN2, MODE_UTF8
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_code_point;
   logic        rsp_bad_lead;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_coding_mode = 2'd0;

   int  mismatch_count;
   int  chars_outstanding;
   int  cycle_count = 0;
   int  bytes_sent = 0;
   int  chars_seen = 0;
   int  mode_writes = 0;
   int  phase_sent;
   bit  steady = 1'b0;
   bit  paused;

   byte_charset_to_ucs2_decoder dut (.*);

   byte_charset_to_ucs2_decoder_checker checker_inst (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < 34);
      if (rsp_valid && !rsp_stall) chars_seen++;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(0, 99) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      phase_sent++;
   endtask

   task automatic wait_results_in();
      req_valid <= 1'b0;
      do @(posedge clock); while (chars_outstanding != 0);
   endtask

   task automatic write_mode(input logic [1:0] mode);
      wait_results_in();
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_coding_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mode_writes++;
   endtask

   task automatic send_utf8_sequence();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         send_byte({1'b0, 7'($urandom)});
      end else if (pick < 60) begin
         send_byte({1'b1, 1'($urandom), 1'b0, 5'($urandom)});
         send_byte($urandom_range(0, 9) == 0 ? 8'($urandom) : {2'b10, 6'($urandom)});
      end else if (pick < 85) begin
         send_byte({1'b1, 1'($urandom), 2'b10, 4'($urandom)});
         send_byte({2'b10, 6'($urandom)});
         send_byte($urandom_range(0, 9) == 0 ? 8'($urandom) : {2'b10, 6'($urandom)});
      end else if (pick < 93) begin
         send_byte({1'b1, 1'($urandom), 2'b11, 4'($urandom)});
      end else begin
         send_byte(8'($urandom));
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hA0);

      write_mode(MODE_LATIN2);
      send_byte(8'h9F);
      send_byte(8'hA0);
      send_byte(8'hFF);

      write_mode(MODE_UTF8);
      send_byte(8'h7F);
      send_byte(8'hC3);
      send_byte(8'hA9);
      send_byte(8'hE2);
      send_byte(8'h82);
      send_byte(8'hAC);
      send_byte(8'hEF);
      send_byte(8'hBF);
      send_byte(8'hBF);
      send_byte(8'h82);
      send_byte(8'h80);
      send_byte(8'hF0);
      send_byte(8'hFF);
      send_byte(8'hC2);
      send_byte(8'hF5);
      send_byte(8'hE0);
      write_mode(MODE_UTF8);
      send_byte(8'h41);

      write_mode(MODE_UNDEFINED);
      send_byte(8'hFF);

      foreach (PHASE_MODES[p]) begin
         write_mode(PHASE_MODES[p]);
         steady = (p == 3);
         phase_sent = 0;
         paused = 1'b0;
         while (phase_sent < PHASE_BYTES) begin
            if (!paused && phase_sent >= 100) begin
               wait_results_in();
               paused = 1'b1;
            end
            if (PHASE_MODES[p] == MODE_UTF8) send_utf8_sequence();
            else send_byte(8'($urandom));
         end
      end
      steady = 1'b0;

      wait_results_in();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Decoded %0d bytes into %0d checked code points over %0d mode writes",
               bytes_sent, chars_seen, mode_writes);
      $display("Modes: Latin-1, Latin-2, UTF-8 and the undefined code, with gaps and stalls");
      if (mismatch_count == 0 && chars_outstanding == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
rtl/bcud_pkg.sv
rtl/bcud_step.sv
rtl/byte_charset_to_ucs2_decoder.sv
rtl/bcud_checker.sv
sim/byte_charset_to_ucs2_decoder_checker.sv
sim/tb_byte_charset_to_ucs2_decoder.sv
